@@ rtl/core/weec_pkg.sv @@
// weec_pkg: shared types, constants and register indexes of the
// wall edge end correction core
// depends on nothing
package weec_pkg;

  // fixed window and offset constants, mm, and the filter start value
  localparam int unsigned FRONT_WINDOW_MM = 80;
  localparam int unsigned EDGE_LOW_MM     = 5;
  localparam int unsigned EDGE_HIGH_MM    = 130;
  localparam int unsigned STOP_EXTRA_MM   = 90;
  localparam int unsigned FILTER_INIT     = 10;

  // field widths
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned SENSE_W  = 8;
  localparam int unsigned FILT_W   = 8;
  localparam int unsigned DIFF_W   = FILT_W + 1;
  localparam int unsigned REG_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 24;

  // restoring divider: one quotient bit a cycle
  localparam int unsigned DIV_STEPS = FILT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // register reset values
  localparam logic [REG_W-1:0] LONG_DIV_RST     = 8'd8;
  localparam logic [REG_W-1:0] SHORT_DIV_RST    = 8'd2;
  localparam logic [REG_W-1:0] FRONT_THR_RST    = 8'd100;
  localparam logic [REG_W-1:0] FRONT_REM_RST    = 8'd40;
  localparam logic [REG_W-1:0] CORNER_REM_RST   = 8'd50;
  localparam logic [REG_W-1:0] FILT_RESET_RST   = 8'd10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_DIV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DIV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_REM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_REM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILT_RESET = 3'd5;

  // trigger source codes
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_FRONT = 2'd1;
  localparam logic [1:0] SRC_RIGHT = 2'd2;
  localparam logic [1:0] SRC_LEFT  = 2'd3;

  // filter slots, also the order in which they are updated
  localparam logic [1:0] OP_RIGHT_SLOW = 2'd0;
  localparam logic [1:0] OP_LEFT_FAST  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/core/wall_edge_end_correction_core.sv @@
// wall_edge_end_correction_core: end distance correction of a forward move
// from front sensor average and side wall edge filters
// depends on weec_pkg
//
// sequence: a reset command goes from accept to ST_FINISH, then to the output
//   register; a tick passes ST_LOAD for each filter slot, ST_DIV for each enabled one
// throughput: one item at a time; each enabled filter takes a load step on the
//   shared restoring divider, then one quotient bit a cycle
// reset: synchronous, active high; registers to their reset values, filters
//   to 10, previous differences and the done flag cleared, no item pending
module wall_edge_end_correction_core
  import weec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_wdata,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // from bit 0: cur_is_forward, next_is_forward, next_is_stop,
  // end_distance[15:0], position[15:0], front_right_dist[7:0],
  // front_left_dist[7:0], side_right_dist[7:0], side_left_dist[7:0],
  // wall_right, wall_left, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // bit 0: cmd
  input  logic                  s_tuser,
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // from bit 0: updated, new_end_distance[15:0], trigger_source[1:0],
  // correction_done, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // configuration registers
  logic [REG_W-1:0] long_divisor;
  logic [REG_W-1:0] short_divisor;
  logic [REG_W-1:0] front_threshold;
  logic [REG_W-1:0] front_remaining;
  logic [REG_W-1:0] corner_remaining;
  logic [REG_W-1:0] filter_reset_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_divisor       <= LONG_DIV_RST;
      short_divisor      <= SHORT_DIV_RST;
      front_threshold    <= FRONT_THR_RST;
      front_remaining    <= FRONT_REM_RST;
      corner_remaining   <= CORNER_REM_RST;
      filter_reset_value <= FILT_RESET_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_LONG_DIV:   long_divisor       <= cfg_wdata;
        CFG_SHORT_DIV:  short_divisor      <= cfg_wdata;
        CFG_FRONT_THR:  front_threshold    <= cfg_wdata;
        CFG_FRONT_REM:  front_remaining    <= cfg_wdata;
        CFG_CORNER_REM: corner_remaining   <= cfg_wdata;
        CFG_FILT_RESET: filter_reset_value <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured input item
  logic              cmd_q;
  logic              cur_fwd_q;
  logic              next_fwd_q;
  logic              next_stop_q;
  logic [DIST_W-1:0] end_q;
  logic [DIST_W-1:0] pos_q;
  logic [SENSE_W-1:0] fr_q;
  logic [SENSE_W-1:0] fl_q;
  logic [SENSE_W-1:0] sr_q;
  logic [SENSE_W-1:0] sl_q;
  logic              wall_right_q;
  logic              wall_left_q;

  // block state
  logic [FILT_W-1:0]        filt [4];   // right slow, right fast, left slow, left fast
  logic signed [DIFF_W-1:0] right_prev;
  logic signed [DIFF_W-1:0] left_prev;
  logic                     done_flag;

  // sequencer
  state_t state, state_next;
  logic [1:0] op;
  logic       op_en;
  logic       in_accept;
  logic       out_load;
  logic       div_load;
  logic       div_step;
  logic       op_adv;

  // shared divider
  logic [FILT_W-1:0]    div_rem;
  logic [FILT_W-1:0]    div_quo;
  logic [FILT_W-1:0]    div_k;
  logic                 div_neg;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_last;
  logic [FILT_W:0]      div_shift;
  logic                 div_ge;
  logic [FILT_W-1:0]    div_rem_next;
  logic [FILT_W-1:0]    div_quo_next;
  logic [FILT_W-1:0]    filt_new;

  // operand set-up for the filter in slot op
  logic [FILT_W-1:0]  op_f;
  logic [SENSE_W-1:0] op_d;
  logic [REG_W-1:0]   op_k_raw;
  logic [FILT_W-1:0]  op_k;
  logic               op_neg;
  logic [FILT_W-1:0]  op_mag;

  // decision logic
  logic signed [DIST_W:0]  rem;
  logic                    active;
  logic                    front_win;
  logic                    edge_win;
  logic [SENSE_W:0]        front_sum;
  logic [SENSE_W-1:0]      front_avg;
  logic                    front_hit;
  logic [DIST_W:0]         front_sum_end;
  logic [DIST_W-1:0]       front_end;
  logic [DIST_W:0]         edge_sum_end;
  logic [DIST_W-1:0]       edge_end;
  logic                    right_en;
  logic                    left_en;
  logic signed [DIFF_W-1:0] right_diff;
  logic signed [DIFF_W-1:0] left_diff;
  logic                    right_hit;
  logic                    left_hit;
  logic                    res_updated;
  logic [DIST_W-1:0]       res_end;
  logic [1:0]              res_src;
  logic                    res_done;

  // gating of a tick: done flag clear, forward move ending here
  assign rem       = $signed({1'b0, end_q}) - $signed({1'b0, pos_q});
  assign active    = !cmd_q && !done_flag && !next_fwd_q && cur_fwd_q;
  assign front_win = rem < $signed((DIST_W+1)'(FRONT_WINDOW_MM));
  assign edge_win  = (rem > $signed((DIST_W+1)'(EDGE_LOW_MM))) &&
                     (rem < $signed((DIST_W+1)'(EDGE_HIGH_MM)));

  // front average, truncated
  assign front_sum = {1'b0, fr_q} + {1'b0, fl_q};
  assign front_avg = front_sum[SENSE_W:1];
  assign front_hit = active && front_win &&
                     (front_avg < front_threshold) && (front_avg > front_remaining);

  // candidate end distances, saturated at 16 bits
  assign front_sum_end = {1'b0, pos_q} + (DIST_W+1)'(front_remaining);
  assign front_end     = front_sum_end[DIST_W] ? '1 : front_sum_end[DIST_W-1:0];
  assign edge_sum_end  = {1'b0, pos_q} + (DIST_W+1)'(corner_remaining) +
                         (next_stop_q ? (DIST_W+1)'(STOP_EXTRA_MM) : '0);
  assign edge_end      = edge_sum_end[DIST_W] ? '1 : edge_sum_end[DIST_W-1:0];

  // side edge detection on the filtered values, slow minus fast
  assign right_en   = active && edge_win && !wall_right_q;
  assign left_en    = active && edge_win && !wall_left_q;
  assign right_diff = $signed({1'b0, filt[0]}) - $signed({1'b0, filt[1]});
  assign left_diff  = $signed({1'b0, filt[2]}) - $signed({1'b0, filt[3]});
  assign right_hit  = right_en && (right_prev > 0) && (right_diff < 0);
  assign left_hit   = left_en && (left_prev > 0) && (left_diff < 0);

  // later writers win: front, then right, then left
  always_comb begin
    priority if (left_hit) begin
      res_end = edge_end;
      res_src = SRC_LEFT;
    end else if (right_hit) begin
      res_end = edge_end;
      res_src = SRC_RIGHT;
    end else if (front_hit) begin
      res_end = front_end;
      res_src = SRC_FRONT;
    end else begin
      res_end = end_q;
      res_src = SRC_NONE;
    end
  end

  assign res_updated = front_hit || right_hit || left_hit;
  assign res_done    = !cmd_q && (done_flag || res_updated);

  // operand selection: odd slots use the short divisor, upper slots the left side
  assign op_f     = filt[op];
  assign op_d     = op[1] ? sl_q : sr_q;
  assign op_k_raw = op[0] ? short_divisor : long_divisor;
  assign op_k     = (op_k_raw == '0) ? FILT_W'(1) : op_k_raw;
  assign op_neg   = op_d < op_f;
  assign op_mag   = op_neg ? (op_f - op_d) : (op_d - op_f);
  assign op_en    = op[1] ? left_en : right_en;

  // one restoring division step on the magnitude
  assign div_shift    = {div_rem, div_quo[FILT_W-1]};
  assign div_ge       = div_shift >= {1'b0, div_k};
  assign div_rem_next = div_ge ? FILT_W'(div_shift - {1'b0, div_k}) : div_shift[FILT_W-1:0];
  assign div_quo_next = {div_quo[FILT_W-2:0], div_ge};
  assign div_last     = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
  // quotient truncates toward zero, so the sign goes on after the magnitude
  assign filt_new     = div_neg ? (op_f - div_quo_next) : (op_f + div_quo_next);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = s_tuser ? ST_FINISH : ST_LOAD;
      end
      ST_LOAD: begin
        if (op_en) state_next = ST_DIV;
        else if (op == OP_LEFT_FAST) state_next = ST_FINISH;
      end
      ST_DIV: begin
        if (div_last) state_next = (op == OP_LEFT_FAST) ? ST_FINISH : ST_LOAD;
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    op_adv   = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_LOAD: begin
        div_load = op_en;
        op_adv   = !op_en;
      end
      ST_DIV: begin
        div_step = 1'b1;
        op_adv   = div_last;
      end
      ST_FINISH: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_RIGHT_SLOW;
    end else if (in_accept) begin
      op <= OP_RIGHT_SLOW;
    end else if (op_adv) begin
      op <= op + 2'd1;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q        <= s_tuser;
      cur_fwd_q    <= s_tdata[0];
      next_fwd_q   <= s_tdata[1];
      next_stop_q  <= s_tdata[2];
      end_q        <= s_tdata[18:3];
      pos_q        <= s_tdata[34:19];
      fr_q         <= s_tdata[42:35];
      fl_q         <= s_tdata[50:43];
      sr_q         <= s_tdata[58:51];
      sl_q         <= s_tdata[66:59];
      wall_right_q <= s_tdata[67];
      wall_left_q  <= s_tdata[68];
    end
  end

  // shared divider registers
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_load) begin
      div_cnt <= '0;
    end else if (div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_rem <= '0;
      div_quo <= op_mag;
      div_k   <= op_k;
      div_neg <= op_neg;
    end else if (div_step) begin
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
    end
  end

  // filters, previous differences, done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) filt[i] <= FILT_W'(FILTER_INIT);
      right_prev <= '0;
      left_prev  <= '0;
      done_flag  <= 1'b0;
    end else if (out_load) begin
      if (cmd_q) begin
        for (int i = 0; i < 4; i++) filt[i] <= filter_reset_value;
        right_prev <= '0;
        left_prev  <= '0;
      end else begin
        if (right_en) right_prev <= right_diff;
        // left side keeps the old difference across a zero
        if (left_en && (left_diff != 0)) left_prev <= left_diff;
      end
      done_flag <= res_done;
    end else if (div_step && div_last) begin
      filt[op] <= filt_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0, res_done, res_src, res_end, res_updated};
    end
  end

endmodule

@@ rtl/core/weec_checker.sv @@
// weec_checker: port level assertions of the wall edge end correction core
// depends on weec_pkg; bound to wall_edge_end_correction_core
module weec_checker
  import weec_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // no item pending straight after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // one item at a time: no accept in the cycle after an accept
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // no update means no trigger source
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[18:17] == SRC_NONE)
    else $error("trigger source without update");

  // an update always sets the done flag and a trigger source
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[19] && (m_tdata[18:17] != SRC_NONE))
    else $error("update without done flag");

endmodule

bind wall_edge_end_correction_core weec_checker u_weec_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/tb_wall_edge_end_correction_core.sv @@
// testbench of the wall edge end correction core: directed and random sensor ticks,
// predicted results checked item by item against the block's outputs
// depends on weec_pkg and wall_edge_end_correction_core
`timescale 1ns / 1ps

module tb_wall_edge_end_correction_core;
  import weec_pkg::*;

  // watchdog limit, well above the slowest correct run
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int          DIST_MAX    = (1 << DIST_W) - 1;

  // one sensor tick or reset command as it enters the block
  typedef struct {
    bit                cmd;
    bit                cur_fwd;
    bit                next_fwd;
    bit                next_stop;
    bit [DIST_W-1:0]   end_dist;
    bit [DIST_W-1:0]   pos;
    bit [SENSE_W-1:0]  front_r;
    bit [SENSE_W-1:0]  front_l;
    bit [SENSE_W-1:0]  side_r;
    bit [SENSE_W-1:0]  side_l;
    bit                wall_r;
    bit                wall_l;
  } tick_t;

  // result item, laid out as m_tdata from bit 0 up
  typedef struct packed {
    logic              done;
    logic [1:0]        source;
    logic [DIST_W-1:0] new_end;
    logic              updated;
  } end_result_t;

  // end distance predictor with the queue of predicted results
  class end_distance_board;
    bit [REG_W-1:0]   long_div   = LONG_DIV_RST;
    bit [REG_W-1:0]   short_div  = SHORT_DIV_RST;
    bit [REG_W-1:0]   front_thr  = FRONT_THR_RST;
    bit [REG_W-1:0]   front_rem  = FRONT_REM_RST;
    bit [REG_W-1:0]   corner_rem = CORNER_REM_RST;
    bit [REG_W-1:0]   filt_init  = FILT_RESET_RST;
    bit [FILT_W-1:0]  right_slow = FILT_W'(FILTER_INIT);
    bit [FILT_W-1:0]  right_fast = FILT_W'(FILTER_INIT);
    bit [FILT_W-1:0]  left_slow  = FILT_W'(FILTER_INIT);
    bit [FILT_W-1:0]  left_fast  = FILT_W'(FILTER_INIT);
    bit signed [DIFF_W-1:0] right_last_diff = '0;
    bit signed [DIFF_W-1:0] left_last_diff  = '0;
    bit               corr_done  = 1'b0;
    end_result_t      expected_ends[$];
    int               errors, checked, resets_seen;
    int               by_source[4];

    function void set_register(logic [CFG_IDX_W-1:0] idx, bit [REG_W-1:0] value);
      case (idx)
        CFG_LONG_DIV:   long_div   = value;
        CFG_SHORT_DIV:  short_div  = value;
        CFG_FRONT_THR:  front_thr  = value;
        CFG_FRONT_REM:  front_rem  = value;
        CFG_CORNER_REM: corner_rem = value;
        CFG_FILT_RESET: filt_init  = value;
        default: ;
      endcase
    endfunction

    // exponential filter step, division truncating toward zero, divisor 0 taken as 1
    function bit [FILT_W-1:0] filter_step(bit [FILT_W-1:0] f, bit [SENSE_W-1:0] d,
                                          bit [REG_W-1:0] k);
      int divisor;
      int delta;
      divisor = (k == 0) ? 1 : int'(k);
      delta = (int'(d) - int'(f)) / divisor;
      return FILT_W'(int'(f) + delta);
    endfunction

    function void accept_tick(tick_t t);
      end_result_t want;
      int rem, edge_end, front_end, avg, diff;
      want.updated = 1'b0;
      want.new_end = t.end_dist;
      want.source  = SRC_NONE;
      if (t.cmd) begin
        right_slow = filt_init;
        right_fast = filt_init;
        left_slow  = filt_init;
        left_fast  = filt_init;
        right_last_diff = '0;
        left_last_diff  = '0;
        corr_done = 1'b0;
        resets_seen++;
      end else if (!corr_done && !t.next_fwd && t.cur_fwd) begin
        rem = int'(t.end_dist) - int'(t.pos);
        edge_end = int'(t.pos) + int'(corner_rem) + (t.next_stop ? int'(STOP_EXTRA_MM) : 0);
        if (edge_end > DIST_MAX) edge_end = DIST_MAX;
        // front pass: truncated average strictly inside the window
        if (rem < int'(FRONT_WINDOW_MM)) begin
          avg = (int'(t.front_r) + int'(t.front_l)) / 2;
          if (avg < int'(front_thr) && avg > int'(front_rem)) begin
            front_end = int'(t.pos) + int'(front_rem);
            if (front_end > DIST_MAX) front_end = DIST_MAX;
            want.new_end = DIST_W'(front_end);
            want.source  = SRC_FRONT;
            want.updated = 1'b1;
            corr_done = 1'b1;
          end
        end
        // side passes: right then left, so left wins a tie
        if (rem > int'(EDGE_LOW_MM) && rem < int'(EDGE_HIGH_MM)) begin
          if (!t.wall_r) begin
            right_slow = filter_step(right_slow, t.side_r, long_div);
            right_fast = filter_step(right_fast, t.side_r, short_div);
            diff = int'(right_slow) - int'(right_fast);
            if (right_last_diff > 0 && diff < 0) begin
              want.new_end = DIST_W'(edge_end);
              want.source  = SRC_RIGHT;
              want.updated = 1'b1;
              corr_done = 1'b1;
            end
            right_last_diff = DIFF_W'(diff);
          end
          if (!t.wall_l) begin
            left_slow = filter_step(left_slow, t.side_l, long_div);
            left_fast = filter_step(left_fast, t.side_l, short_div);
            diff = int'(left_slow) - int'(left_fast);
            if (left_last_diff > 0 && diff < 0) begin
              want.new_end = DIST_W'(edge_end);
              want.source  = SRC_LEFT;
              want.updated = 1'b1;
              corr_done = 1'b1;
            end
            // a zero difference leaves the left history alone
            if (diff != 0) left_last_diff = DIFF_W'(diff);
          end
        end
      end
      want.done = corr_done;
      expected_ends.push_back(want);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      end_result_t got, want;
      got = data[$bits(end_result_t)-1:0];
      if (expected_ends.size() == 0) begin
        $error("result item with no input pending: %h", data);
        errors++;
        return;
      end
      want = expected_ends.pop_front();
      checked++;
      if (got.updated !== want.updated) begin
        $error("updated: expected %0d, got %0d", want.updated, got.updated);
        errors++;
      end
      if (got.new_end !== want.new_end) begin
        $error("new_end_distance: expected %0d, got %0d", want.new_end, got.new_end);
        errors++;
      end
      if (got.source !== want.source) begin
        $error("trigger_source: expected %0d, got %0d", want.source, got.source);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("correction_done: expected %0d, got %0d", want.done, got.done);
        errors++;
      end
      if (want.updated) by_source[want.source]++;
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  end_distance_board board;
  int unsigned       items_sent = 0;
  int unsigned       sender_idle_pct = 13;
  int unsigned       recv_idle_pct   = 78;
  logic              hold_off = 1'b0;

  wall_edge_end_correction_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #1 clk = ~clk;

  // receiver: random back-pressure, forced low during the long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    wait (items_sent >= 1000);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // idling follows the progress of the run: sender light/receiver heavy,
  // then the reverse, then none
  task automatic send_tick(input tick_t t);
    if (items_sent < 450) begin
      sender_idle_pct = 13;
      recv_idle_pct   = 78;
    end else if (items_sent < 900) begin
      sender_idle_pct = 78;
      recv_idle_pct   = 13;
    end else begin
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= t.cmd;
    s_tdata  <= {3'b000, t.wall_l, t.wall_r, t.side_l, t.side_r, t.front_l, t.front_r,
                 t.pos, t.end_dist, t.next_stop, t.next_fwd, t.cur_fwd};
    do @(posedge clk); while (!s_tready);
    board.accept_tick(t);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [REG_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_register(idx, value);
  endtask

  task automatic apply_setting(bit [REG_W-1:0] l_div, s_div, thr, f_rem, c_rem, f_init);
    write_reg(CFG_LONG_DIV, l_div);
    write_reg(CFG_SHORT_DIV, s_div);
    write_reg(CFG_FRONT_THR, thr);
    write_reg(CFG_FRONT_REM, f_rem);
    write_reg(CFG_CORNER_REM, c_rem);
    write_reg(CFG_FILT_RESET, f_init);
    cfg_wen <= 1'b0;
  endtask

  // stop offering and let every pending result drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.expected_ends.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // forward move about to end, both front sensors alike
  function automatic tick_t fwd_tick(int end_d, int pos_d, int front, int side,
                                     bit wr, bit wl);
    tick_t t;
    t.cmd       = 1'b0;
    t.cur_fwd   = 1'b1;
    t.next_fwd  = 1'b0;
    t.next_stop = 1'b0;
    t.end_dist  = DIST_W'(end_d);
    t.pos       = DIST_W'(pos_d);
    t.front_r   = SENSE_W'(front);
    t.front_l   = SENSE_W'(front);
    t.side_r    = SENSE_W'(side);
    t.side_l    = SENSE_W'(side);
    t.wall_r    = wr;
    t.wall_l    = wl;
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.cmd       = ($urandom_range(7) == 0);
    t.cur_fwd   = 1'($urandom_range(1));
    t.next_fwd  = 1'($urandom_range(1));
    t.next_stop = 1'($urandom_range(1));
    t.end_dist  = DIST_W'($urandom);
    t.pos       = DIST_W'($urandom);
    t.front_r   = SENSE_W'($urandom);
    t.front_l   = SENSE_W'($urandom);
    t.side_r    = SENSE_W'($urandom);
    t.side_l    = SENSE_W'($urandom);
    t.wall_r    = 1'($urandom_range(1));
    t.wall_l    = 1'($urandom_range(1));
    return t;
  endfunction

  // reset command, then a forward move closing in on its end with side
  // levels that drop and rise so that wall edges show up
  task automatic run_move();
    tick_t      t;
    int         rem, p, steps, level_r, level_l;
    bit [DIST_W-1:0] end_d;
    bit         wr, wl;
    t = random_tick();
    t.cmd = 1'b1;
    send_tick(t);
    end_d = ($urandom_range(3) == 0) ? DIST_W'($urandom_range(65235, 65535))
                                     : DIST_W'($urandom_range(200, 65535));
    rem     = int'($urandom_range(60, 200));
    steps   = int'($urandom_range(8, 40));
    wr      = ($urandom_range(2) == 0);
    wl      = ($urandom_range(2) == 0);
    level_r = int'($urandom_range(255));
    level_l = int'($urandom_range(255));
    repeat (steps) begin
      t.cmd       = 1'b0;
      t.cur_fwd   = ($urandom_range(19) != 0);
      t.next_fwd  = ($urandom_range(9) == 0);
      t.next_stop = 1'($urandom_range(1));
      p = int'(end_d) - rem;
      if (p < 0) p = 0;
      else if (p > DIST_MAX) p = DIST_MAX;
      t.end_dist = end_d;
      t.pos      = DIST_W'(p);
      if ($urandom_range(4) == 0) begin
        t.front_r = SENSE_W'($urandom_range(160));
        t.front_l = SENSE_W'($urandom_range(160));
      end else begin
        t.front_r = SENSE_W'($urandom_range(180, 255));
        t.front_l = t.front_r;
      end
      if ($urandom_range(3) == 0)
        level_r = (level_r < 128) ? int'($urandom_range(140, 255)) : int'($urandom_range(100));
      if ($urandom_range(3) == 0)
        level_l = (level_l < 128) ? int'($urandom_range(140, 255)) : int'($urandom_range(100));
      t.side_r = SENSE_W'(level_r) ^ SENSE_W'($urandom_range(3));
      t.side_l = SENSE_W'(level_l) ^ SENSE_W'($urandom_range(3));
      if ($urandom_range(9) == 0) wr = !wr;
      if ($urandom_range(9) == 0) wl = !wl;
      t.wall_r = wr;
      t.wall_l = wl;
      send_tick(t);
      rem -= int'($urandom_range(9));
    end
  endtask

  initial begin
    tick_t t;
    int unsigned phase_end;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset register values
    t = fwd_tick(DIST_MAX, DIST_MAX, 255, 255, 1, 1);      // every field at its top
    t.cmd = 1'b1;
    t.next_fwd = 1'b1;
    t.next_stop = 1'b1;
    send_tick(t);
    send_tick(fwd_tick(DIST_MAX, DIST_MAX, 70, 0, 1, 1));   // front trigger, sum saturates
    send_tick(fwd_tick(DIST_MAX, DIST_MAX, 70, 0, 1, 1));   // already done
    t = fwd_tick(0, 0, 0, 0, 0, 0);                         // every field at its bottom
    t.cmd = 1'b1;
    t.cur_fwd = 1'b0;
    send_tick(t);
    t = fwd_tick(100, 60, 70, 0, 1, 1);
    t.cur_fwd = 1'b0;                                       // not a forward move
    send_tick(t);
    t = fwd_tick(100, 60, 70, 0, 1, 1);
    t.next_fwd = 1'b1;                                      // next move goes on forward
    send_tick(t);
    send_tick(fwd_tick(100, 100, 100, 0, 1, 1));            // average on the threshold
    send_tick(fwd_tick(100, 100, 40, 0, 1, 1));             // average on the lower bound
    t = fwd_tick(100, 200, 81, 0, 1, 1);                    // end behind position
    t.front_l = 8'd80;                                      // average truncates to 80
    send_tick(t);
    t = fwd_tick(0, 0, 0, 0, 0, 0);
    t.cmd = 1'b1;
    send_tick(t);
    send_tick(fwd_tick(1080, 1000, 70, 0, 1, 1));           // front window edge
    send_tick(fwd_tick(1005, 1000, 255, 0, 0, 0));          // edge window lower edge
    send_tick(fwd_tick(1130, 1000, 255, 0, 0, 0));          // edge window upper edge
    send_tick(fwd_tick(1100, 1000, 255, 0, 0, 1));          // right side drops
    t = fwd_tick(DIST_MAX, 65450, 255, 255, 0, 1);          // right edge, stop, saturates
    t.next_stop = 1'b1;
    send_tick(t);
    send_tick(t.cmd ? t : fwd_tick(0, 0, 0, 0, 0, 0));
    t = fwd_tick(0, 0, 0, 0, 0, 0);
    t.cmd = 1'b1;
    send_tick(t);
    // left keeps its history on a zero difference, right does not
    send_tick(fwd_tick(1000, 900, 255, 0, 0, 0));
    send_tick(fwd_tick(1000, 900, 255, 13, 0, 0));
    send_tick(fwd_tick(1000, 900, 255, 255, 0, 0));
    send_tick(t);
    // both sides fire in one tick, left wins
    send_tick(fwd_tick(1000, 900, 255, 0, 0, 0));
    t = fwd_tick(1000, 900, 255, 255, 0, 0);
    t.next_stop = 1'b1;
    send_tick(t);
    t.cmd = 1'b1;
    send_tick(t);
    // front and right in one tick, right wins
    send_tick(fwd_tick(1000, 950, 255, 0, 0, 1));
    send_tick(fwd_tick(1000, 950, 70, 255, 0, 1));

    // random part over several register settings, extremes among them
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        1: apply_setting(8'd255, 8'd1, 8'd255, 8'd0, 8'd255, 8'd255);
        2: apply_setting(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
        3: apply_setting(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
                         REG_W'($urandom), REG_W'($urandom), REG_W'($urandom));
        4: apply_setting(8'd16, 8'd3, 8'd120, 8'd30, 8'd60, 8'd100);
        default: ;
      endcase
      phase_end = items_sent + 250;
      while (items_sent < phase_end) begin
        if ($urandom_range(6) == 0) send_tick(random_tick());
        else run_move();
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d reset commands, 5 register settings",
             items_sent, board.checked, board.resets_seen);
    $display("corrections seen: %0d front, %0d right edge, %0d left edge",
             board.by_source[SRC_FRONT], board.by_source[SRC_RIGHT],
             board.by_source[SRC_LEFT]);
    if (board.errors == 0 && board.expected_ends.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
